### rtl/fw2d_pkg.sv
// Shared types, codes and the control program of the 2-D Fenwick tree block.
package fw2d_pkg;

  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_COLS_DEF = 64;

  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = CFG_IDX_W'(1);
  localparam logic [CFG_DAT_W-1:0] SIZE_RESET = CFG_DAT_W'(64);

  localparam logic REQ_ADD = 1'b0;
  localparam logic REQ_QUERY = 1'b1;
  localparam logic STAT_DONE = 1'b0;
  localparam logic STAT_RANGE = 1'b1;

  typedef struct packed {
    logic req_type;
    logic [5:0] row;
    logic [5:0] col;
    logic [5:0] row_end;
    logic [5:0] col_end;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic signed [63:0] rect_sum;
    logic status;
  } rsp_t;

  // Datapath operations.
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NOP = 4'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 4'd1;
  localparam logic [OP_W-1:0] OP_LOAD = 4'd2;
  localparam logic [OP_W-1:0] OP_ADD_JSTART = 4'd3;
  localparam logic [OP_W-1:0] OP_ADD_READ = 4'd4;
  localparam logic [OP_W-1:0] OP_ADD_WRITE = 4'd5;
  localparam logic [OP_W-1:0] OP_ADD_INEXT = 4'd6;
  localparam logic [OP_W-1:0] OP_Q_START = 4'd7;
  localparam logic [OP_W-1:0] OP_Q_ISTART = 4'd8;
  localparam logic [OP_W-1:0] OP_Q_JSTART = 4'd9;
  localparam logic [OP_W-1:0] OP_Q_READ = 4'd10;
  localparam logic [OP_W-1:0] OP_Q_INEXT = 4'd11;
  localparam logic [OP_W-1:0] OP_Q_NEXTK = 4'd12;
  localparam logic [OP_W-1:0] OP_FINISH = 4'd13;

  // Jump conditions.
  localparam int CND_W = 4;
  localparam logic [CND_W-1:0] C_NEXT = 4'd0;
  localparam logic [CND_W-1:0] C_ALWAYS = 4'd1;
  localparam logic [CND_W-1:0] C_ITEM = 4'd2;
  localparam logic [CND_W-1:0] C_BAD = 4'd3;
  localparam logic [CND_W-1:0] C_QUERY = 4'd4;
  localparam logic [CND_W-1:0] C_ROW_END = 4'd5;
  localparam logic [CND_W-1:0] C_COL_MORE = 4'd6;
  localparam logic [CND_W-1:0] C_ROW_NEG = 4'd7;
  localparam logic [CND_W-1:0] C_COL_MORE_DN = 4'd8;
  localparam logic [CND_W-1:0] C_K_MORE = 4'd9;
  localparam logic [CND_W-1:0] C_OUT_FREE = 4'd10;
  localparam logic [CND_W-1:0] C_CLR_LAST = 4'd11;

  // Program steps.
  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] STEP_CLR = 4'd0;
  localparam logic [PC_W-1:0] STEP_IDLE = 4'd1;
  localparam logic [PC_W-1:0] STEP_CHECK = 4'd2;
  localparam logic [PC_W-1:0] STEP_DISPATCH = 4'd3;
  localparam logic [PC_W-1:0] STEP_A_ROW = 4'd4;
  localparam logic [PC_W-1:0] STEP_A_RD = 4'd5;
  localparam logic [PC_W-1:0] STEP_A_WR = 4'd6;
  localparam logic [PC_W-1:0] STEP_A_NEXT = 4'd7;
  localparam logic [PC_W-1:0] STEP_Q_START = 4'd8;
  localparam logic [PC_W-1:0] STEP_Q_ROW = 4'd9;
  localparam logic [PC_W-1:0] STEP_Q_COL = 4'd10;
  localparam logic [PC_W-1:0] STEP_Q_RD = 4'd11;
  localparam logic [PC_W-1:0] STEP_Q_NEXT = 4'd12;
  localparam logic [PC_W-1:0] STEP_Q_K = 4'd13;
  localparam logic [PC_W-1:0] STEP_FINISH = 4'd14;

  // When the condition fails, a word with hold set repeats its step.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [CND_W-1:0] cond;
    logic hold;
    logic [PC_W-1:0] target;
  } uword_t;

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, hold: 1'b0, target: STEP_IDLE};
    unique case (pc)
      STEP_CLR:      w = '{op: OP_CLEAR, cond: C_CLR_LAST, hold: 1'b1, target: STEP_IDLE};
      STEP_IDLE:     w = '{op: OP_LOAD, cond: C_ITEM, hold: 1'b1, target: STEP_CHECK};
      STEP_CHECK:    w = '{op: OP_NOP, cond: C_BAD, hold: 1'b0, target: STEP_FINISH};
      STEP_DISPATCH: w = '{op: OP_NOP, cond: C_QUERY, hold: 1'b0, target: STEP_Q_START};
      STEP_A_ROW:    w = '{op: OP_ADD_JSTART, cond: C_ROW_END, hold: 1'b0, target: STEP_FINISH};
      STEP_A_RD:     w = '{op: OP_ADD_READ, cond: C_NEXT, hold: 1'b0, target: STEP_A_WR};
      STEP_A_WR:     w = '{op: OP_ADD_WRITE, cond: C_COL_MORE, hold: 1'b0, target: STEP_A_RD};
      STEP_A_NEXT:   w = '{op: OP_ADD_INEXT, cond: C_ALWAYS, hold: 1'b0, target: STEP_A_ROW};
      STEP_Q_START:  w = '{op: OP_Q_START, cond: C_NEXT, hold: 1'b0, target: STEP_Q_ROW};
      STEP_Q_ROW:    w = '{op: OP_Q_ISTART, cond: C_NEXT, hold: 1'b0, target: STEP_Q_COL};
      STEP_Q_COL:    w = '{op: OP_Q_JSTART, cond: C_ROW_NEG, hold: 1'b0, target: STEP_Q_K};
      STEP_Q_RD:     w = '{op: OP_Q_READ, cond: C_COL_MORE_DN, hold: 1'b0, target: STEP_Q_RD};
      STEP_Q_NEXT:   w = '{op: OP_Q_INEXT, cond: C_ALWAYS, hold: 1'b0, target: STEP_Q_COL};
      STEP_Q_K:      w = '{op: OP_Q_NEXTK, cond: C_K_MORE, hold: 1'b0, target: STEP_Q_ROW};
      STEP_FINISH:   w = '{op: OP_FINISH, cond: C_OUT_FREE, hold: 1'b1, target: STEP_IDLE};
      default:       w = '{op: OP_NOP, cond: C_ALWAYS, hold: 1'b0, target: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

### rtl/fw2d_ram.sv
// Generic single-port RAM with registered read data.
module fw2d_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### rtl/fenwick_2d_point_add_rect_sum.sv
// Add: walks the tree rows and columns upward from the item's cell, reading then writing back each visited cell.
// Query: sums four corner prefixes, walking tree rows and columns downward and reading each cell.
// One item at a time; the single-port tree RAM sets the pace.
// A rejected item goes straight to finish; a result waits in an output register.
// Reset: synchronous; then a clearing pass zeroes all 2**(log2 rows + log2 cols) tree words
// (4096 by default) with in_ready low; config writes are always taken.
module fenwick_2d_point_add_rect_sum #(
  parameter int MAX_ROWS = fw2d_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = fw2d_pkg::MAX_COLS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fw2d_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fw2d_pkg::CFG_DAT_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  fw2d_pkg::req_t                 in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output fw2d_pkg::rsp_t                 out_data
);

  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);
  localparam int AW = RW + CW;
  localparam int DEPTH = 1 << AW;
  localparam int BIGW = (RW > CW) ? RW : CW;
  // Walk registers: room for one step past the end and a sign bit for -1.
  localparam int WW = ((BIGW > fw2d_pkg::CFG_DAT_W) ? BIGW : fw2d_pkg::CFG_DAT_W) + 2;

  logic [fw2d_pkg::PC_W-1:0] pc;
  logic [fw2d_pkg::PC_W-1:0] pc_next;
  fw2d_pkg::uword_t uw;
  logic taken;

  logic [fw2d_pkg::CFG_DAT_W-1:0] rows_in_use;
  logic [fw2d_pkg::CFG_DAT_W-1:0] cols_in_use;
  logic [WW-1:0] nr;
  logic [WW-1:0] nc;

  fw2d_pkg::req_t item;
  logic [WW-1:0] i;
  logic [WW-1:0] j;
  logic [WW-1:0] i_up;
  logic [WW-1:0] j_up;
  logic [WW-1:0] i_dn;
  logic [WW-1:0] j_dn;
  logic [1:0] k;
  logic [63:0] acc;
  logic pend;
  logic pend_sub;
  logic [AW-1:0] clr;
  logic bad;
  logic item_go;
  logic fin_go;
  logic [63:0] value_ext;

  logic [AW-1:0] ram_addr;
  logic ram_we;
  logic [63:0] ram_wdata;
  logic [63:0] ram_rdata;

  assign uw = fw2d_pkg::ucode(pc);
  assign cfg_ready = 1'b1;
  assign in_ready = (uw.op == fw2d_pkg::OP_LOAD);
  assign item_go = in_valid && in_ready;
  assign fin_go = (uw.op == fw2d_pkg::OP_FINISH) && !(out_valid && !out_ready);

  assign nr = (WW'(rows_in_use) > WW'(MAX_ROWS)) ? WW'(MAX_ROWS) : WW'(rows_in_use);
  assign nc = (WW'(cols_in_use) > WW'(MAX_COLS)) ? WW'(MAX_COLS) : WW'(cols_in_use);

  assign i_up = i | (i + WW'(1));
  assign j_up = j | (j + WW'(1));
  assign i_dn = (i & (i + WW'(1))) - WW'(1);
  assign j_dn = (j & (j + WW'(1))) - WW'(1);

  always_comb begin
    bad = (WW'(item.row) >= nr) || (WW'(item.col) >= nc);
    if (item.req_type == fw2d_pkg::REQ_QUERY) begin
      bad = bad || (WW'(item.row_end) >= nr) || (WW'(item.col_end) >= nc);
    end
  end

  always_comb begin
    unique case (uw.cond)
      fw2d_pkg::C_NEXT:        taken = 1'b0;
      fw2d_pkg::C_ALWAYS:      taken = 1'b1;
      fw2d_pkg::C_ITEM:        taken = item_go;
      fw2d_pkg::C_BAD:         taken = bad;
      fw2d_pkg::C_QUERY:       taken = (item.req_type == fw2d_pkg::REQ_QUERY);
      fw2d_pkg::C_ROW_END:     taken = (i >= nr);
      fw2d_pkg::C_COL_MORE:    taken = (j_up < nc);
      fw2d_pkg::C_ROW_NEG:     taken = i[WW-1];
      fw2d_pkg::C_COL_MORE_DN: taken = !j_dn[WW-1];
      fw2d_pkg::C_K_MORE:      taken = (k != 2'd3);
      fw2d_pkg::C_OUT_FREE:    taken = fin_go;
      fw2d_pkg::C_CLR_LAST:    taken = &clr;
      default:                 taken = 1'b0;
    endcase
    if (taken) begin
      pc_next = uw.target;
    end else if (uw.hold) begin
      pc_next = pc;
    end else begin
      pc_next = pc + fw2d_pkg::PC_W'(1);
    end
  end

  assign value_ext = {{32{item.value[31]}}, item.value};
  assign ram_we = (uw.op == fw2d_pkg::OP_CLEAR) || (uw.op == fw2d_pkg::OP_ADD_WRITE);
  assign ram_addr = (uw.op == fw2d_pkg::OP_CLEAR) ? clr : {i[RW-1:0], j[CW-1:0]};
  assign ram_wdata = (uw.op == fw2d_pkg::OP_CLEAR) ? 64'd0 : (ram_rdata + value_ext);

  fw2d_ram #(
    .WIDTH(64),
    .DEPTH(DEPTH)
  ) u_tree (
    .clk(clk),
    .addr(ram_addr),
    .we(ram_we),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= fw2d_pkg::STEP_CLR;
      clr <= '0;
      rows_in_use <= fw2d_pkg::SIZE_RESET;
      cols_in_use <= fw2d_pkg::SIZE_RESET;
      out_valid <= 1'b0;
      pend <= 1'b0;
    end else begin
      pc <= pc_next;
      if (uw.op == fw2d_pkg::OP_CLEAR) begin
        clr <= clr + AW'(1);
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == fw2d_pkg::CFG_ROWS) begin
          rows_in_use <= cfg_data;
        end else if (cfg_index == fw2d_pkg::CFG_COLS) begin
          cols_in_use <= cfg_data;
        end
      end
      if (fin_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      // A query read is skipped when the column walk has already gone past zero.
      pend <= (uw.op == fw2d_pkg::OP_Q_READ) && !j[WW-1];
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    pend_sub <= k[0] ^ k[1];
    if (uw.op == fw2d_pkg::OP_Q_START) begin
      acc <= '0;
    end else if (pend) begin
      acc <= pend_sub ? (acc - ram_rdata) : (acc + ram_rdata);
    end
    if (fin_go) begin
      out_data.status <= bad ? fw2d_pkg::STAT_RANGE : fw2d_pkg::STAT_DONE;
      out_data.rect_sum <= (!bad && item.req_type == fw2d_pkg::REQ_QUERY) ? acc : 64'd0;
    end
    unique case (uw.op)
      fw2d_pkg::OP_LOAD: begin
        if (item_go) begin
          item <= in_data;
          i <= WW'(in_data.row);
        end
      end
      fw2d_pkg::OP_ADD_JSTART: j <= WW'(item.col);
      fw2d_pkg::OP_ADD_WRITE:  j <= j_up;
      fw2d_pkg::OP_ADD_INEXT:  i <= i_up;
      fw2d_pkg::OP_Q_START:    k <= 2'd0;
      // Corner order: (r1,c1) +, (r0-1,c1) -, (r1,c0-1) -, (r0-1,c0-1) +.
      fw2d_pkg::OP_Q_ISTART:   i <= k[0] ? (WW'(item.row) - WW'(1)) : WW'(item.row_end);
      fw2d_pkg::OP_Q_JSTART:   j <= k[1] ? (WW'(item.col) - WW'(1)) : WW'(item.col_end);
      fw2d_pkg::OP_Q_READ:     j <= j_dn;
      fw2d_pkg::OP_Q_INEXT:    i <= i_dn;
      fw2d_pkg::OP_Q_NEXTK:    k <= k + 2'd1;
      default: ;
    endcase
  end

endmodule

### rtl/fw2d_checker.sv
// Port-level checks for the 2-D Fenwick tree block, bound to its top level.
module fw2d_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input fw2d_pkg::rsp_t out_data
);

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // The tree is swept clean after reset before any item is taken.
  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("input taken during the clearing pass");

  // Only one item is worked on at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

  // A rejected item carries a zero sum.
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == fw2d_pkg::STAT_RANGE) |-> out_data.rect_sum == 64'd0)
    else $error("rejected item with nonzero sum");

endmodule

bind fenwick_2d_point_add_rect_sum fw2d_checker u_fw2d_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_valid),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data(out_data)
);
